@@ rtl/capture_period_meter_defines.svh @@
// ---------------------------------------------------------------------------
// capture_period_meter_defines
// assertion macros shared by the capture period meter rtl
// ---------------------------------------------------------------------------
`ifndef CAPTURE_PERIOD_METER_DEFINES_SVH
`define CAPTURE_PERIOD_METER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("capture_period_meter assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("capture_period_meter assertion failed");

`endif

@@ rtl/cpm_pkg.sv @@
// ---------------------------------------------------------------------------
// cpm_pkg
// types, codes and constants of the capture period meter
// ---------------------------------------------------------------------------
package cpm_pkg;

    localparam int RING_SLOTS_DEF = 12;

    // shared divider: 40-bit dividend, 32-bit divisor, one quotient bit per cycle
    localparam int DIV_W  = 40;
    localparam int ITER_W = $clog2(DIV_W + 1);

    localparam logic [2:0] OP_OVERFLOW = 3'd0;
    localparam logic [2:0] OP_CAPTURE  = 3'd1;
    localparam logic [2:0] OP_POP      = 3'd2;
    localparam logic [2:0] OP_COUNT    = 3'd3;
    localparam logic [2:0] OP_DRAIN    = 3'd4;

    localparam logic        REG_CLOCK_HZ   = 1'b0;
    localparam logic [31:0] CLOCK_HZ_RESET = 32'd16000000;
    localparam logic [15:0] LOW_WORD_GUARD = 16'hFF00;
    localparam logic [31:0] EMPTY_POP      = 32'hFFFF_FFFF;
    localparam logic [39:0] NO_SIGNAL_Q8   = 40'd490752;
    localparam logic [39:0] FREQ_SAT       = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] capture_low;
        logic        overflow_pending;
    } t_in_item;

    typedef struct packed {
        logic [31:0] period_value;
        logic [5:0]  stored_count;
        logic [39:0] frequency_q8;
        logic        no_signal;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_DRAIN,
        ST_DIV_AVG,
        ST_DIV_FREQ,
        ST_EMIT
    } t_state;

endpackage

@@ rtl/cpm_ram.sv @@
// ---------------------------------------------------------------------------
// cpm_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module cpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/capture_period_meter.sv @@
// ---------------------------------------------------------------------------
// capture_period_meter
// input capture period meter: extended timestamps, period ring, averaging
// ---------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall, word i_in) takes one opcode word.
//   overflow tick and capture finish in the accepting cycle, no result.
//   count query goes straight to the emit state; a non-empty pop awaits its ram read.
//   drain: n ring ram reads, a wait for the last read data, a load of the
//   shared restoring divider, then 32+clog2(RING_SLOTS) steps for the mean and
//   40 for the frequency; a zero mean skips the second, an empty ring all of it.
//   o_in_stall is high from acceptance of a query until its result is loaded
//   into the output register; drains also wait on the single divider.
//   output channel (o_out_valid / i_out_stall, word o_out) holds its word while
//   stalled; ticks and captures are still taken meanwhile, but a new result
//   waits in the last sequencer state, input stalled, until the register frees.
//   apb byte address 0 holds clock_hz; write it only while idle (not enforced).
//   synchronous reset clears high word, last stamp, ring pointers, clock_hz to
//   16 MHz and the output valid; ring contents stay undefined, no clearing pass.
// ---------------------------------------------------------------------------
`include "capture_period_meter_defines.svh"

module capture_period_meter #(
    parameter int RING_SLOTS = cpm_pkg::RING_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cpm_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cpm_pkg::t_out_item o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    import cpm_pkg::*;

    localparam int IDX_W = $clog2(RING_SLOTS);
    localparam int SUM_W = 32 + IDX_W;
    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(RING_SLOTS - 1);

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        return (idx == SLOT_LAST) ? '0 : IDX_W'(idx + 1'b1);
    endfunction

    t_state r_state, n_state;

    logic [31:0]      r_clock_hz;
    logic [15:0]      r_hw, n_hw;
    logic [31:0]      r_prev, n_prev;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic             r_rd_pend, n_rd_pend;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [IDX_W-1:0] r_n, n_n;
    logic [DIV_W-1:0] r_dvd, n_dvd;
    logic [32:0]      r_rem, n_rem;
    logic [31:0]      r_dsr, n_dsr;
    logic [ITER_W-1:0] r_iter, n_iter;
    t_out_item        r_res, n_res;
    t_out_item        r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [31:0]      ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [31:0]      ram_rdata;

    logic             w_accept;
    logic             w_empty;
    logic [IDX_W:0]   w_diff;
    logic [IDX_W-1:0] w_held;
    logic             w_out_free;
    logic [15:0]      w_cap_hw;
    logic [31:0]      w_stamp;
    logic [IDX_W-1:0] w_cap_slot;
    logic [32:0]      w_shift;
    logic [33:0]      w_trial;
    logic             w_ge;
    logic [32:0]      w_rem_step;
    logic [DIV_W-1:0] w_dvd_step;
    logic             w_avg_last;
    logic             w_frq_last;
    logic [31:0]      w_avg;

    cpm_ram #(
        .WIDTH (32),
        .DEPTH (RING_SLOTS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CLOCK_HZ) ? r_clock_hz : 32'd0;

    // ring occupancy
    assign w_empty = (r_head == r_tail);
    assign w_diff  = {1'b0, r_head} - {1'b0, r_tail};
    assign w_held  = w_diff[IDX_W] ? IDX_W'(w_diff + (IDX_W + 1)'(RING_SLOTS))
                                   : w_diff[IDX_W-1:0];

    // capture timestamp, pending overflow only counts below the guard
    assign w_cap_hw = (i_in.overflow_pending && (i_in.capture_low < LOW_WORD_GUARD))
                      ? 16'(r_hw + 1'b1) : r_hw;
    assign w_stamp    = {w_cap_hw, i_in.capture_low};
    assign w_cap_slot = next_slot(r_head);

    // shared restoring divider step
    assign w_shift    = {r_rem[31:0], r_dvd[DIV_W-1]};
    assign w_trial    = {1'b0, w_shift} - {2'b00, r_dsr};
    assign w_ge       = !w_trial[33];
    assign w_rem_step = w_ge ? w_trial[32:0] : w_shift;
    assign w_dvd_step = {r_dvd[DIV_W-2:0], w_ge};
    assign w_avg_last = (r_iter == ITER_W'(SUM_W - 1));
    assign w_frq_last = (r_iter == ITER_W'(DIV_W - 1));
    assign w_avg      = w_dvd_step[31:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.opcode)
                        OP_POP:   n_state = w_empty ? ST_EMIT : ST_POP_WAIT;
                        OP_COUNT: n_state = ST_EMIT;
                        OP_DRAIN: n_state = w_empty ? ST_EMIT : ST_DRAIN;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_POP_WAIT: n_state = ST_EMIT;
            ST_DRAIN: begin
                if (w_empty && !r_rd_pend) begin
                    n_state = ST_DIV_AVG;
                end
            end
            ST_DIV_AVG: begin
                if (w_avg_last) begin
                    n_state = (w_avg == 32'd0) ? ST_EMIT : ST_DIV_FREQ;
                end
            end
            ST_DIV_FREQ: begin
                if (w_frq_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_hw        = r_hw;
        n_prev      = r_prev;
        n_head      = r_head;
        n_tail      = r_tail;
        n_rd_pend   = 1'b0;
        n_sum       = r_sum;
        n_n         = r_n;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_dsr       = r_dsr;
        n_iter      = r_iter;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = w_cap_slot;
        ram_wdata   = w_stamp - r_prev;
        ram_re      = 1'b0;
        ram_raddr   = next_slot(r_tail);

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res.period_value = 32'd0;
                    n_res.stored_count = 6'(w_held);
                    n_res.frequency_q8 = 40'd0;
                    n_res.no_signal    = 1'b0;
                    case (i_in.opcode)
                        OP_OVERFLOW: n_hw = 16'(r_hw + 1'b1);
                        OP_CAPTURE: begin
                            n_hw   = w_cap_hw;
                            n_prev = w_stamp;
                            ram_we = 1'b1;
                            n_head = w_cap_slot;
                            // full ring drops the oldest period
                            if (w_cap_slot == r_tail) begin
                                n_tail = next_slot(r_tail);
                            end
                        end
                        OP_POP: begin
                            if (w_empty) begin
                                n_res.period_value = EMPTY_POP;
                            end else begin
                                ram_re = 1'b1;
                                n_tail = next_slot(r_tail);
                            end
                        end
                        OP_DRAIN: begin
                            n_sum = '0;
                            n_n   = w_held;
                            if (w_empty) begin
                                n_res.frequency_q8 = NO_SIGNAL_Q8;
                                n_res.no_signal    = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP_WAIT: n_res.period_value = ram_rdata;
            ST_DRAIN: begin
                if (!w_empty) begin
                    ram_re    = 1'b1;
                    n_rd_pend = 1'b1;
                    n_tail    = next_slot(r_tail);
                end
                if (r_rd_pend) begin
                    n_sum = r_sum + SUM_W'(ram_rdata);
                end
                if (w_empty && !r_rd_pend) begin
                    // left-align the sum so the divider runs SUM_W steps only
                    n_dvd  = {r_sum, {(DIV_W - SUM_W){1'b0}}};
                    n_rem  = '0;
                    n_dsr  = 32'(r_n);
                    n_iter = '0;
                end
            end
            ST_DIV_AVG: begin
                n_dvd  = w_dvd_step;
                n_rem  = w_rem_step;
                n_iter = ITER_W'(r_iter + 1'b1);
                if (w_avg_last) begin
                    if (w_avg == 32'd0) begin
                        n_res.frequency_q8 = FREQ_SAT;
                    end else begin
                        n_dvd  = {r_clock_hz, 8'h00};
                        n_rem  = '0;
                        n_dsr  = w_avg;
                        n_iter = '0;
                    end
                end
            end
            ST_DIV_FREQ: begin
                n_dvd  = w_dvd_step;
                n_rem  = w_rem_step;
                n_iter = ITER_W'(r_iter + 1'b1);
                if (w_frq_last) begin
                    n_res.frequency_q8 = w_dvd_step;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_clock_hz  <= CLOCK_HZ_RESET;
            r_hw        <= '0;
            r_prev      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hw        <= n_hw;
            r_prev      <= n_prev;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && (paddr[2] == REG_CLOCK_HZ)) begin
                r_clock_hz <= pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_n    <= n_n;
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
        r_iter <= n_iter;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    `CPM_ASSERT_IMPL(a_ptr_range, i_clk, i_rst_n, 1'b1, (r_head < RING_SLOTS) && (r_tail < RING_SLOTS))
    `CPM_ASSERT_IMPL(a_drained_empty, i_clk, i_rst_n, r_state == ST_DIV_AVG, r_head == r_tail)
    `CPM_ASSERT_IMPL(a_freq_divisor, i_clk, i_rst_n, r_state == ST_DIV_FREQ, r_dsr != 32'd0)
    `CPM_ASSERT_NEXT(a_emit_load, i_clk, i_rst_n, (r_state == ST_EMIT) && w_out_free, r_out_valid && (r_state == ST_IDLE))

endmodule

@@ verif/capture_period_meter_test.sv @@
// ---------------------------------------------------------------------------
// capture_period_meter_test
// self-checking bench for the capture period meter: a directed table of
// corner words, then bursts of captures and ticks closed by queries, checked
// against a cycle-free prediction of timestamps, ring, pop, count and drain
// ---------------------------------------------------------------------------
module capture_period_meter_test;
    import cpm_pkg::*;

    localparam int SLOTS          = RING_SLOTS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int IDLE_SETTLE    = 8;
    localparam int DRAIN_SETTLE   = 120;
    localparam int MAX_REPORTS    = 10;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
    localparam logic [2:0] ADDR_CLOCK_HZ   = {REG_CLOCK_HZ, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;

    typedef struct {
        t_in_item  word;
        bit        typed;
        t_out_item reading;
    } stim_row_t;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_word;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // predicted state of the meter
    logic [31:0] meter_clock_hz   = CLOCK_HZ_RESET;
    logic [15:0] meter_high       = '0;
    logic [31:0] meter_last_stamp = '0;
    logic [31:0] meter_ring [SLOTS];
    int          meter_head = 0;
    int          meter_tail = 0;

    t_out_item readings_due [$];
    int        words_sent       = 0;
    int        readings_checked = 0;
    int        mismatches       = 0;
    int        quiet_cycles     = 0;
    int        holds_wanted     = 0;
    int        holds_done       = 0;
    bit        gaps_on          = 1'b1;

    stim_row_t directed_rows [22] = '{
        '{'{OP_COUNT,        16'h0000, 1'b0}, 1'b1, '{32'd0, 6'd0, 40'd0, 1'b0}},
        '{'{OP_POP,          16'h0000, 1'b0}, 1'b1, '{EMPTY_POP, 6'd0, 40'd0, 1'b0}},
        '{'{OP_DRAIN,        16'h0000, 1'b0}, 1'b1, '{32'd0, 6'd0, NO_SIGNAL_Q8, 1'b1}},
        '{'{OP_CAPTURE,      16'h0000, 1'b0}, 1'b0, '0},
        '{'{OP_CAPTURE,      16'h0000, 1'b0}, 1'b0, '0},
        // both periods are zero, so the average is zero and the result saturates
        '{'{OP_DRAIN,        16'h0000, 1'b0}, 1'b1, '{32'd0, 6'd2, FREQ_SAT, 1'b0}},
        '{'{OP_UNUSED_FIRST, 16'hFFFF, 1'b1}, 1'b0, '0},
        '{'{OP_UNUSED_LAST,  16'hFFFF, 1'b1}, 1'b0, '0},
        '{'{OP_UNUSED_LAST,  16'h0000, 1'b0}, 1'b0, '0},
        '{'{OP_OVERFLOW,     16'h0000, 1'b0}, 1'b0, '0},
        '{'{OP_CAPTURE,      16'hFFFF, 1'b1}, 1'b0, '0},
        '{'{OP_CAPTURE,      16'hFEFF, 1'b1}, 1'b0, '0},
        '{'{OP_CAPTURE,      16'hFF00, 1'b1}, 1'b0, '0},
        // low word falls back, period wraps
        '{'{OP_CAPTURE,      16'h0010, 1'b0}, 1'b0, '0},
        '{'{OP_COUNT,        16'hFFFF, 1'b1}, 1'b0, '0},
        '{'{OP_POP,          16'hFFFF, 1'b1}, 1'b0, '0},
        '{'{OP_POP,          16'h0000, 1'b0}, 1'b0, '0},
        '{'{OP_DRAIN,        16'hFFFF, 1'b1}, 1'b0, '0},
        '{'{OP_OVERFLOW,     16'hFFFF, 1'b1}, 1'b0, '0},
        '{'{OP_CAPTURE,      16'h8000, 1'b1}, 1'b0, '0},
        '{'{OP_COUNT,        16'h0000, 1'b0}, 1'b0, '0},
        '{'{OP_DRAIN,        16'h0000, 1'b0}, 1'b0, '0}
    };

    capture_period_meter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic int next_slot(input int idx);
        return (idx + 1 >= SLOTS) ? 0 : idx + 1;
    endfunction

    // advances the predicted state by one word, returns 1 when a reading is due
    function automatic bit predict_reading(input t_in_item w, output t_out_item r);
        logic [31:0] stamp;
        logic [63:0] sum;
        logic [63:0] avg;
        logic [63:0] quot;
        int          held;
        int          n;
        r = '0;
        if (w.opcode == OP_OVERFLOW) begin
            meter_high = meter_high + 16'd1;
            return 1'b0;
        end
        if (w.opcode == OP_CAPTURE) begin
            if (w.overflow_pending && w.capture_low < LOW_WORD_GUARD) begin
                meter_high = meter_high + 16'd1;
            end
            stamp = {meter_high, w.capture_low};
            n = next_slot(meter_head);
            // full ring drops its oldest period
            if (n == meter_tail) begin
                meter_tail = next_slot(meter_tail);
            end
            meter_ring[n] = stamp - meter_last_stamp;
            meter_last_stamp = stamp;
            meter_head = n;
            return 1'b0;
        end
        if (w.opcode > OP_DRAIN) begin
            return 1'b0;
        end
        held = (meter_head >= meter_tail) ? meter_head - meter_tail
                                          : SLOTS + meter_head - meter_tail;
        r.stored_count = 6'(held);
        if (w.opcode == OP_POP) begin
            if (meter_head == meter_tail) begin
                r.period_value = EMPTY_POP;
            end else begin
                meter_tail = next_slot(meter_tail);
                r.period_value = meter_ring[meter_tail];
            end
        end else if (w.opcode == OP_DRAIN) begin
            sum = '0;
            n = 0;
            while (meter_head != meter_tail) begin
                meter_tail = next_slot(meter_tail);
                sum = sum + 64'(meter_ring[meter_tail]);
                n++;
            end
            if (n == 0) begin
                r.frequency_q8 = NO_SIGNAL_Q8;
                r.no_signal = 1'b1;
            end else begin
                avg = sum / 64'(n);
                if (avg == 0) begin
                    r.frequency_q8 = FREQ_SAT;
                end else begin
                    quot = {24'd0, meter_clock_hz, 8'd0} / avg;
                    r.frequency_q8 = quot[39:0];
                end
            end
        end
        return 1'b1;
    endfunction

    // offers one word from a falling edge, returns at the falling edge after it is taken
    task automatic send_word(input t_in_item w, input bit typed, input t_out_item typed_reading);
        t_out_item r;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_word = w;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        if (predict_reading(w, r)) begin
            readings_due.push_back(typed ? typed_reading : r);
        end
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        while (readings_due.size() != 0) @(negedge i_clk);
        repeat (IDLE_SETTLE) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_CLOCK_HZ) begin
            meter_clock_hz = data;
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // bursts of captures, ticks and unused opcodes, each closed by one query
    task automatic run_random(input int count);
        t_in_item w;
        int       burst;
        int       done;
        int       pick;
        done = 0;
        while (done < count) begin
            burst = $urandom_range(0, 15);
            for (int k = 0; k <= burst; k++) begin
                w.capture_low = 16'($urandom);
                w.overflow_pending = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 99);
                if (k == burst) begin
                    if (pick < 35) begin
                        w.opcode = OP_POP;
                    end else if (pick < 60) begin
                        w.opcode = OP_COUNT;
                    end else begin
                        w.opcode = OP_DRAIN;
                    end
                end else if (pick < 5) begin
                    w.opcode = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
                end else if (pick < 30) begin
                    w.opcode = OP_OVERFLOW;
                end else begin
                    w.opcode = OP_CAPTURE;
                    // low words around the guard value
                    if (pick >= 85) begin
                        w.capture_low = 16'($urandom_range(LOW_WORD_GUARD - 16,
                                                           LOW_WORD_GUARD + 16));
                    end
                end
                send_word(w, 1'b0, '0);
                if (w.opcode <= OP_DRAIN) begin
                    done++;
                end
            end
        end
        in_valid = 1'b0;
    endtask

    // receiver: short random holds, and a long one on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (holds_done < holds_wanted) begin
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                out_stall = 1'b0;
                holds_done++;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                out_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            readings_checked++;
            if (readings_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected word: period=%h count=%0d freq=%h nosig=%b",
                             out_word.period_value, out_word.stored_count,
                             out_word.frequency_q8, out_word.no_signal);
                end
            end else begin
                want = readings_due.pop_front();
                if (out_word !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("word %0d: expected period=%h count=%0d freq=%h nosig=%b",
                                 readings_checked, want.period_value, want.stored_count,
                                 want.frequency_q8, want.no_signal);
                        $display("word %0d:      got period=%h count=%0d freq=%h nosig=%b",
                                 readings_checked, out_word.period_value,
                                 out_word.stored_count, out_word.frequency_q8,
                                 out_word.no_signal);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("capture_period_meter: mismatch");
            $finish;
        end
    end

    initial begin
        t_in_item w;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].reading);
        end
        in_valid = 1'b0;
        wait_idle();

        apb_write(ADDR_CLOCK_HZ, 32'hFFFF_FFFF);
        run_random(350);
        wait_idle();

        apb_write(ADDR_CLOCK_HZ, 32'd1);
        run_random(300);
        wait_idle();

        apb_write(ADDR_CLOCK_HZ, 32'd0);
        // no register there, clock_hz stays zero
        apb_write(ADDR_UNMAPPED, 32'h0000_3039);
        // zero clock still saturates on a zero average: repeat the last stamp
        w = '{OP_CAPTURE, meter_last_stamp[15:0], 1'b0};
        send_word(w, 1'b0, '0);
        w.opcode = OP_DRAIN;
        send_word(w, 1'b0, '0);
        w.opcode = OP_CAPTURE;
        send_word(w, 1'b0, '0);
        w.opcode = OP_DRAIN;
        send_word(w, 1'b0, '0);
        run_random(250);
        wait_idle();

        apb_write(ADDR_CLOCK_HZ, 32'($urandom));
        holds_wanted = 1;
        run_random(300);
        gaps_on = 1'b0;
        run_random(150);

        while (readings_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_SETTLE) @(negedge i_clk);

        $display("sent %0d words, checked %0d results, %0d mismatches", words_sent,
                 readings_checked, mismatches);
        $display("clock_hz at reset, all ones, one, zero and random; ring overrun, long hold");
        if (mismatches == 0 && readings_due.size() == 0) begin
            $display("capture_period_meter: match");
        end else begin
            $display("capture_period_meter: mismatch");
        end
        $finish;
    end

endmodule
